// ===== rtl/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg - shared definitions for the radix digit converter
// Constants, controller states, command/status structs and the digit to
// ASCII mapping used by the controller and the datapath.
// ----------------------------------------------------------------------------
package i2rd_pkg;

    // Field widths and defaults
    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;

    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_ERR    = 8'h00;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_PUSH = 6'b000100,
        ST_READ = 6'b001000,
        ST_LOAD = 6'b010000,
        ST_SEND = 6'b100000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_value;   // take the input word, clear counters
        logic div_step;     // one quotient bit of the division
        logic push_digit;   // store remainder on the digit stack
        logic pop_digit;    // read top of the digit stack
        logic load_out;     // output register from the popped digit
        logic load_err;     // output register with the error word
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;     // this step produces the last quotient bit
        logic quot_zero;    // quotient is zero, no more digits
        logic radix_bad;    // configured base above the maximum
        logic out_last;     // output register holds the final word
    } dp_stat_t;

    // Digit value to ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + d_ext;
        end else begin
            return CHAR_ALPHA + d_ext - {{(CHAR_W-RADIX_W){1'b0}}, DEC_DIGITS};
        end
    endfunction

endpackage

// ===== rtl/i2rd_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2rd_ctrl - sequencing controller for the radix digit converter
// Steps the datapath through division, digit stacking and output of the
// digits most significant first.
// ----------------------------------------------------------------------------
module i2rd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output i2rd_pkg::dp_cmd_t  cmd,
    input  i2rd_pkg::dp_stat_t stat
);
    import i2rd_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands; s_tready is high in idle, m_tvalid in send
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (stat.radix_bad) begin
                        cmd.load_err = 1'b1;
                        state_next   = ST_SEND;
                    end else begin
                        cmd.load_value = 1'b1;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push_digit = 1'b1;
                state_next     = stat.quot_zero ? ST_READ : ST_DIV;
            end
            ST_READ: begin
                cmd.pop_digit = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_out = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = stat.out_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/i2rd_datapath.sv =====
// ----------------------------------------------------------------------------
// i2rd_datapath - divider, digit stack and output register
// Bit-serial restoring division by the configured base, a stack of digit
// values and the registered output word.
// ----------------------------------------------------------------------------
module i2rd_datapath #(
    parameter int VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [i2rd_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic [VALUE_BITS-1:0]        in_value,
    input  i2rd_pkg::dp_cmd_t            cmd,
    output i2rd_pkg::dp_stat_t           stat,
    output logic [i2rd_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last,
    output logic                         out_bad
);
    import i2rd_pkg::*;

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(VALUE_BITS - 1);

    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [RADIX_W-1:0]    rem_reg;
    logic [IDX_W-1:0]      bit_cnt_reg;
    logic [CNT_W-1:0]      dig_cnt_reg;
    logic [RADIX_W-1:0]    rd_data_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic                  bad_reg;

    logic [RADIX_W-1:0] dig_mem [VALUE_BITS];

    logic [RADIX_W:0]   rem_sh;
    logic               q_bit;
    logic [RADIX_W-1:0] rem_next;
    logic [CNT_W-1:0]   dig_cnt_dec;

    // Base register; writes below the minimum are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en && (cfg_wr_data >= RADIX_MIN)) begin
            radix_reg <= cfg_wr_data;
        end
    end

    // One restoring division step
    always_comb begin
        rem_sh   = {rem_reg, quot_reg[VALUE_BITS-1]};
        q_bit    = (rem_sh >= {1'b0, radix_reg});
        rem_next = q_bit ? RADIX_W'(rem_sh - {1'b0, radix_reg}) : rem_sh[RADIX_W-1:0];
    end

    assign dig_cnt_dec = dig_cnt_reg - CNT_W'(1);

    // Quotient, remainder and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            if (cmd.load_value) begin
                bit_cnt_reg <= '0;
                dig_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                bit_cnt_reg <= bit_cnt_reg + IDX_W'(1);
            end else if (cmd.push_digit) begin
                bit_cnt_reg <= '0;
                dig_cnt_reg <= dig_cnt_reg + CNT_W'(1);
            end else if (cmd.pop_digit) begin
                dig_cnt_reg <= dig_cnt_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_value) begin
            quot_reg <= in_value;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], q_bit};
            rem_reg  <= rem_next;
        end else if (cmd.push_digit) begin
            rem_reg  <= '0;
        end
    end

    // Digit stack, registered read
    always_ff @(posedge aclk) begin
        if (cmd.push_digit) begin
            dig_mem[dig_cnt_reg[IDX_W-1:0]] <= rem_reg;
        end
        if (cmd.pop_digit) begin
            rd_data_reg <= dig_mem[dig_cnt_dec[IDX_W-1:0]];
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (cmd.load_err) begin
            char_reg <= CHAR_ERR;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end else if (cmd.load_out) begin
            char_reg <= digit_to_ascii(rd_data_reg);
            last_reg <= (dig_cnt_reg == '0);
            bad_reg  <= 1'b0;
        end
    end

    assign out_char = char_reg;
    assign out_last = last_reg;
    assign out_bad  = bad_reg;

    // Status to the controller
    assign stat.div_done  = (bit_cnt_reg == LAST_BIT);
    assign stat.quot_zero = (quot_reg == '0);
    assign stat.radix_bad = (radix_reg > RADIX_MAX);
    assign stat.out_last  = last_reg;

endmodule

// ===== rtl/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits - integer to ASCII digits in a configured base
// Converts each input word to its digits in base 2..36, most significant
// first, one output word per digit; a base above 36 gives one error word.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_       | in  | tdata: value
//  m_       | out | tdata: digit_char, tlast: is_last, tuser: bad_radix
//  cfg_     | in  | wr_data: radix (writes of 0 or 1 ignored)
//
//  An item with n digits takes n rounds of bit-serial division, one
//  quotient bit per cycle, each ending in a push of the digit, then per
//  digit out a stack read, output load and send, plus any output stall.
//  An error item loads the error word, then sends it.
//  s_tready is high only when no item is in progress.
//  Reset (aresetn low, synchronous) sets the base to 10 and the block idle.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [i2rd_pkg::RADIX_W-1:0]        cfg_wr_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // [VALUE_BITS-1:0] value
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [i2rd_pkg::CHAR_W-1:0]         m_tdata,   // [7:0] digit_char
    output logic                                m_tlast,   // is_last
    output logic                                m_tuser    // [0] bad_radix
);
    import i2rd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    i2rd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Divider, digit stack and output word
    i2rd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_value    (s_tdata[VALUE_BITS-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .out_char    (m_tdata),
        .out_last    (m_tlast),
        .out_bad     (m_tuser)
    );

endmodule
